@@ design/gxy2_pkg.sv @@
// ----------------------------------------------------------------------------
// gxy2_pkg
// Shared types, codes and helpers of the XY2 galvo rectangle-path transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gxy2_pkg;

    // Field widths fixed by the channel definitions
    localparam int FIELD_W    = 16;
    localparam int CMD_W      = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECT  = 2'd2;

    // Register indexes (word index, paddr[2])
    localparam logic REG_SETTLE_TICKS = 1'b0;

    // Reset value of the settle register
    localparam logic [FIELD_W-1:0] SETTLE_RESET = 16'd64;

    // Rectangle side codes
    typedef logic [2:0] side_t;
    localparam side_t SIDE_NONE   = 3'd0;
    localparam side_t SIDE_BOTTOM = 3'd1;
    localparam side_t SIDE_RIGHT  = 3'd2;
    localparam side_t SIDE_TOP    = 3'd3;
    localparam side_t SIDE_LEFT   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FIELD_W-1:0] x_coord;
        logic [FIELD_W-1:0] y_coord;
        logic [FIELD_W-1:0] rect_width;
        logic [FIELD_W-1:0] rect_height;
    } step_req_t;

    typedef struct packed {
        logic               clock_running;
        logic               sync_level;
        logic               x_line;
        logic               y_line;
        logic               accepted;
        logic               busy_res;
        logic [FIELD_W-1:0] x_position;
        logic [FIELD_W-1:0] y_position;
    } step_res_t;

    // First side at or after 'from' whose length is non-zero, else none
    function automatic side_t first_side_from(input logic [3:0] from,
                                              input logic w_nz,
                                              input logic h_nz);
        side_t res;
        logic  len_nz;
        res = SIDE_NONE;
        for (int s = 4; s >= 1; s--)
        begin
            len_nz = (s == 1 || s == 3) ? w_nz : h_nz;
            if (4'(s) >= from && len_nz)
            begin
                res = side_t'(s);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/gxy2_if.sv @@
// ----------------------------------------------------------------------------
// gxy2 channel interfaces
// Valid/ready channels for command requests and per-step results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gxy2_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [15:0] rect_width;
    logic [15:0] rect_height;

    modport source (output valid, command, x_coord, y_coord, rect_width, rect_height,
                    input ready);
    modport sink   (input valid, command, x_coord, y_coord, rect_width, rect_height,
                    output ready);
endinterface

interface gxy2_rsp_if;
    logic        valid;
    logic        ready;
    logic        clock_running;
    logic        sync_level;
    logic        x_line;
    logic        y_line;
    logic        accepted;
    logic        busy_res;
    logic [15:0] x_position;
    logic [15:0] y_position;

    modport source (output valid, clock_running, sync_level, x_line, y_line, accepted,
                    busy_res, x_position, y_position,
                    input ready);
    modport sink   (input valid, clock_running, sync_level, x_line, y_line, accepted,
                    busy_res, x_position, y_position,
                    output ready);
endinterface

`default_nettype wire

@@ design/gxy2_apb_regs.sv @@
// ----------------------------------------------------------------------------
// gxy2_apb_regs
// APB register file holding the settle tick count.
// ----------------------------------------------------------------------------
`default_nettype none

module gxy2_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gxy2_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gxy2_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gxy2_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [gxy2_pkg::FIELD_W-1:0]      settle_ticks
);

    logic                           wr_settle;
    logic [gxy2_pkg::FIELD_W-1:0]   settle_reg;

    // Decode a write to the settle register in the access phase
    assign wr_settle = psel && penable && pwrite
                       && (paddr[2] == gxy2_pkg::REG_SETTLE_TICKS);

    // Hold the settle tick count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= gxy2_pkg::SETTLE_RESET;
        end
        else if (wr_settle)
        begin
            settle_reg <= pwdata[gxy2_pkg::FIELD_W-1:0];
        end
    end

    // Read back; addresses beyond the register list read as zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == gxy2_pkg::REG_SETTLE_TICKS)
        begin
            prdata = {{(gxy2_pkg::APB_DATA_W-gxy2_pkg::FIELD_W){1'b0}}, settle_reg};
        end
    end

    assign pready       = 1'b1;
    assign settle_ticks = settle_reg;

endmodule

`default_nettype wire

@@ design/gxy2_step_core.sv @@
// ----------------------------------------------------------------------------
// gxy2_step_core
// Transmitter state and single-step update: frame slots, settle count and
// rectangle perimeter walk, advanced once per enabled request.
// ----------------------------------------------------------------------------
`default_nettype none

module gxy2_step_core #(
    parameter int COORD_BITS  = 16,
    parameter int SETTLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  gxy2_pkg::step_req_t           req,
    input  logic [gxy2_pkg::FIELD_W-1:0]  settle_ticks,
    output gxy2_pkg::step_res_t           res
);

    localparam int FRAME_SLOTS = COORD_BITS + 4;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS + 1);
    localparam int BIT_W       = $clog2(COORD_BITS);
    localparam int FW          = gxy2_pkg::FIELD_W;

    localparam logic [SLOT_W-1:0] SLOT_HDR_ONE = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_PARITY  = SLOT_W'(COORD_BITS + 3);
    localparam logic [SLOT_W-1:0] SLOT_MSB_REF = SLOT_W'(COORD_BITS + 2);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FRAME  = 2'd1;
    localparam logic [1:0] PH_SETTLE = 2'd2;

    logic [1:0]               phase_reg,    phase_next;
    logic [SLOT_W-1:0]        slot_reg,     slot_next;
    logic [COORD_BITS-1:0]    x_shift_reg,  x_shift_next;
    logic [COORD_BITS-1:0]    y_shift_reg,  y_shift_next;
    logic                     x_par_reg,    x_par_next;
    logic                     y_par_reg,    y_par_next;
    logic [SETTLE_BITS-1:0]   settle_reg,   settle_next;
    gxy2_pkg::side_t          side_reg,     side_next;
    logic [FW-1:0]            index_reg,    index_next;
    logic [COORD_BITS-1:0]    corner_x_reg, corner_x_next;
    logic [COORD_BITS-1:0]    corner_y_reg, corner_y_next;
    logic [FW-1:0]            width_reg,    width_next;
    logic [FW-1:0]            height_reg,   height_next;
    logic [COORD_BITS-1:0]    last_x_reg,   last_x_next;
    logic [COORD_BITS-1:0]    last_y_reg,   last_y_next;
    logic [1:0]               lines_reg,    lines_next;

    // Walk advance after a finished point
    logic [FW-1:0]            idx_inc;
    logic [FW-1:0]            cur_len;
    gxy2_pkg::side_t          fin_side;
    logic [FW-1:0]            fin_index;
    logic [COORD_BITS-1:0]    fin_x;
    logic [COORD_BITS-1:0]    fin_y;
    logic [COORD_BITS-1:0]    w_ext;
    logic [COORD_BITS-1:0]    h_ext;
    logic [COORD_BITS-1:0]    i_ext;

    // Step control
    logic                     load_en;
    logic [COORD_BITS-1:0]    load_x;
    logic [COORD_BITS-1:0]    load_y;
    logic                     do_finish;
    logic                     clk_run;
    logic                     sync_on;
    logic                     acc;
    logic [SLOT_W-1:0]        bit_pos;
    logic                     bx;
    logic                     by;
    logic [SETTLE_BITS-1:0]   settle_load;
    logic [SETTLE_BITS-1:0]   settle_dec;

    // Work out the next walk side, index and point from stored state
    always_comb
    begin
        idx_inc = index_reg + FW'(1);
        cur_len = (side_reg == gxy2_pkg::SIDE_BOTTOM || side_reg == gxy2_pkg::SIDE_TOP)
                  ? width_reg : height_reg;
        fin_side  = side_reg;
        fin_index = index_reg;
        if (side_reg != gxy2_pkg::SIDE_NONE)
        begin
            if (idx_inc >= cur_len)
            begin
                fin_side  = gxy2_pkg::first_side_from({1'b0, side_reg} + 4'd1,
                                                      |width_reg, |height_reg);
                fin_index = '0;
            end
            else
            begin
                fin_index = idx_inc;
            end
        end

        w_ext = COORD_BITS'(width_reg);
        h_ext = COORD_BITS'(height_reg);
        i_ext = COORD_BITS'(fin_index);
        unique case (fin_side)
            gxy2_pkg::SIDE_BOTTOM:
            begin
                fin_x = corner_x_reg + i_ext;
                fin_y = corner_y_reg;
            end
            gxy2_pkg::SIDE_RIGHT:
            begin
                fin_x = corner_x_reg + w_ext;
                fin_y = corner_y_reg + i_ext;
            end
            gxy2_pkg::SIDE_TOP:
            begin
                fin_x = corner_x_reg + w_ext - i_ext;
                fin_y = corner_y_reg + h_ext;
            end
            default:
            begin
                fin_x = corner_x_reg;
                fin_y = corner_y_reg + h_ext - i_ext;
            end
        endcase
    end

    // Advance one step
    always_comb
    begin
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        x_shift_next  = x_shift_reg;
        y_shift_next  = y_shift_reg;
        x_par_next    = x_par_reg;
        y_par_next    = y_par_reg;
        settle_next   = settle_reg;
        side_next     = side_reg;
        index_next    = index_reg;
        corner_x_next = corner_x_reg;
        corner_y_next = corner_y_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        lines_next    = lines_reg;

        load_en     = 1'b0;
        load_x      = '0;
        load_y      = '0;
        do_finish   = 1'b0;
        clk_run     = 1'b0;
        sync_on     = 1'b0;
        acc         = 1'b0;
        bx          = 1'b0;
        by          = 1'b0;
        bit_pos     = SLOT_MSB_REF - slot_reg;
        settle_load = SETTLE_BITS'(settle_ticks);
        settle_dec  = settle_reg - SETTLE_BITS'(settle_reg != '0);

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.command == gxy2_pkg::CMD_POINT)
                begin
                    acc       = 1'b1;
                    side_next = gxy2_pkg::SIDE_NONE;
                    load_en   = 1'b1;
                    load_x    = COORD_BITS'(req.x_coord);
                    load_y    = COORD_BITS'(req.y_coord);
                end
                else if (req.command == gxy2_pkg::CMD_RECT)
                begin
                    acc           = 1'b1;
                    corner_x_next = COORD_BITS'(req.x_coord);
                    corner_y_next = COORD_BITS'(req.y_coord);
                    width_next    = req.rect_width;
                    height_next   = req.rect_height;
                    index_next    = '0;
                    // The first perimeter point is always the corner itself
                    side_next     = (|req.rect_width)  ? gxy2_pkg::SIDE_BOTTOM :
                                    (|req.rect_height) ? gxy2_pkg::SIDE_RIGHT  :
                                                         gxy2_pkg::SIDE_NONE;
                    load_en       = (|req.rect_width) || (|req.rect_height);
                    load_x        = COORD_BITS'(req.x_coord);
                    load_y        = COORD_BITS'(req.y_coord);
                end
            end
            PH_FRAME:
            begin
                clk_run = 1'b1;
                sync_on = 1'b1;
                if (slot_reg < SLOT_HDR_ONE)
                begin
                    bx = 1'b0;
                    by = 1'b0;
                end
                else if (slot_reg == SLOT_HDR_ONE)
                begin
                    bx = 1'b1;
                    by = 1'b1;
                end
                else if (slot_reg < SLOT_PARITY)
                begin
                    bx         = x_shift_reg[bit_pos[BIT_W-1:0]];
                    by         = y_shift_reg[bit_pos[BIT_W-1:0]];
                    x_par_next = x_par_reg ^ bx;
                    y_par_next = y_par_reg ^ by;
                end
                else
                begin
                    bx = x_par_reg;
                    by = y_par_reg;
                end
                lines_next = {bx, by};
                slot_next  = slot_reg + SLOT_W'(1);
                // Close the frame on the parity slot
                if (slot_reg == SLOT_PARITY)
                begin
                    last_x_next = x_shift_reg;
                    last_y_next = y_shift_reg;
                    settle_next = settle_load;
                    if (settle_load == '0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SETTLE;
                    end
                end
            end
            default:
            begin
                clk_run     = 1'b1;
                settle_next = settle_dec;
                if (settle_dec == '0)
                begin
                    do_finish = 1'b1;
                end
            end
        endcase

        // Hand over to the next walk point or drop back to idle
        if (do_finish)
        begin
            side_next  = fin_side;
            index_next = fin_index;
            if (fin_side != gxy2_pkg::SIDE_NONE)
            begin
                load_en = 1'b1;
                load_x  = fin_x;
                load_y  = fin_y;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end

        // Load a fresh frame
        if (load_en)
        begin
            x_shift_next = load_x;
            y_shift_next = load_y;
            x_par_next   = 1'b0;
            y_par_next   = 1'b0;
            slot_next    = '0;
            phase_next   = PH_FRAME;
        end
    end

    // State registers, advanced once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            slot_reg     <= '0;
            x_shift_reg  <= '0;
            y_shift_reg  <= '0;
            x_par_reg    <= 1'b0;
            y_par_reg    <= 1'b0;
            settle_reg   <= '0;
            side_reg     <= gxy2_pkg::SIDE_NONE;
            index_reg    <= '0;
            corner_x_reg <= '0;
            corner_y_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            lines_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            slot_reg     <= slot_next;
            x_shift_reg  <= x_shift_next;
            y_shift_reg  <= y_shift_next;
            x_par_reg    <= x_par_next;
            y_par_reg    <= y_par_next;
            settle_reg   <= settle_next;
            side_reg     <= side_next;
            index_reg    <= index_next;
            corner_x_reg <= corner_x_next;
            corner_y_reg <= corner_y_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            lines_reg    <= lines_next;
        end
    end

    // Result of this step, taken from the updated state
    always_comb
    begin
        res.clock_running = clk_run;
        res.sync_level    = sync_on;
        res.x_line        = lines_next[1];
        res.y_line        = lines_next[0];
        res.accepted      = acc;
        res.busy_res      = (phase_next != PH_IDLE);
        res.x_position    = last_x_next[FW-1:0];
        res.y_position    = last_y_next[FW-1:0];
    end

endmodule

`default_nettype wire

@@ design/galvo_rect_path_xy2_transmitter.sv @@
// ----------------------------------------------------------------------------
// galvo_rect_path_xy2_transmitter
// XY2-style galvo serial transmitter with point and rectangle-walk commands.
//
//   Channel | Dir | Handshake          | Contents
//   --------+-----+--------------------+----------------------------------------
//   req     | in  | valid/ready        | command, x/y coord, rect width/height
//   rsp     | out | valid/ready        | line levels, sync, clock, status, pos
//   apb     | in  | psel/penable/pready| settle_ticks register at byte 0
//
// One request in and one result out per cycle when neither side stalls.
// A request is held in the input register and stepped through the core once
// the output register can take its result, which is registered there for rsp.
// The output register frees the input side: a new request is taken while a
// result waits, and both stages hold while rsp stalls.
// Reset puts the transmitter idle with the lines low and settle_ticks at 64.
// ----------------------------------------------------------------------------
`default_nettype none

module galvo_rect_path_xy2_transmitter #(
    parameter int COORD_BITS  = 16,
    parameter int SETTLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gxy2_req_if.sink                          req,
    gxy2_rsp_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gxy2_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gxy2_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [gxy2_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                           in_valid_reg, in_valid_next;
    gxy2_pkg::step_req_t            in_req_reg;
    logic                           out_valid_reg, out_valid_next;
    gxy2_pkg::step_res_t            out_res_reg;
    gxy2_pkg::step_res_t            core_res;
    logic                           step_fire;
    logic                           req_take;
    logic [gxy2_pkg::FIELD_W-1:0]   settle_ticks;

    gxy2_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .settle_ticks (settle_ticks)
    );

    gxy2_step_core #(
        .COORD_BITS  (COORD_BITS),
        .SETTLE_BITS (SETTLE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_fire),
        .req          (in_req_reg),
        .settle_ticks (settle_ticks),
        .res          (core_res)
    );

    // Step when a request is held and the output register can take its result
    assign step_fire = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || step_fire;
    assign req_take  = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_req_reg.command     <= req.command;
            in_req_reg.x_coord     <= req.x_coord;
            in_req_reg.y_coord     <= req.y_coord;
            in_req_reg.rect_width  <= req.rect_width;
            in_req_reg.rect_height <= req.rect_height;
        end
    end

    // Capture the step result
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_res_reg <= core_res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.clock_running = out_res_reg.clock_running;
    assign rsp.sync_level    = out_res_reg.sync_level;
    assign rsp.x_line        = out_res_reg.x_line;
    assign rsp.y_line        = out_res_reg.y_line;
    assign rsp.accepted      = out_res_reg.accepted;
    assign rsp.busy_res      = out_res_reg.busy_res;
    assign rsp.x_position    = out_res_reg.x_position;
    assign rsp.y_position    = out_res_reg.y_position;

endmodule

`default_nettype wire

@@ design/gxy2_checker.sv @@
// ----------------------------------------------------------------------------
// gxy2_checker
// Port-level checks of the transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gxy2_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_clock_running,
    input logic rsp_sync_level,
    input logic rsp_accepted,
    input logic rsp_busy_res
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // Hold the result flags while stalled
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_accepted) && $stable(rsp_busy_res)
                                    && $stable(rsp_sync_level))
        else $error("stalled result changed");

    // A taken command only loads a point and drives no slot
    a_accept_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_accepted |-> !rsp_clock_running && !rsp_sync_level)
        else $error("slot driven on the command step");

    // Sync only rises with a running line clock
    a_sync_clock: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_sync_level |-> rsp_clock_running)
        else $error("sync high without clock");

    // A result appearing on an empty output follows a taken request
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without a request");

endmodule

bind galvo_rect_path_xy2_transmitter gxy2_checker u_gxy2_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_clock_running (rsp.clock_running),
    .rsp_sync_level    (rsp.sync_level),
    .rsp_accepted      (rsp.accepted),
    .rsp_busy_res      (rsp.busy_res)
);

`default_nettype wire
